@@ src/msa_pkg.sv @@
// ----------------------------------------------------------------------------
// msa_pkg: shared definitions for the moment superset accumulator
// Table depth, field widths, command codes and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package msa_pkg;

  localparam int NUM_MOMENTS = 1024;
  localparam int KEY_WORDS   = 2;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 10;
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 64;
  localparam int CFG_W  = 11;
  localparam int MCNT_W = 11;

  localparam int AW    = (NUM_MOMENTS > 1) ? $clog2(NUM_MOMENTS) : 1;
  localparam int CNT_W = $clog2(NUM_MOMENTS + 1);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam int NUM_RESET = 1024;
  localparam int N_RESET   = (NUM_RESET > NUM_MOMENTS) ? NUM_MOMENTS : NUM_RESET;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_WORDS >= 2) ? {KEY_W{1'b1}} : {{(KEY_W-32){1'b0}}, {32{1'b1}}};

  localparam logic [MCNT_W-1:0] MCNT_MAX = {MCNT_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_KEY_WRITE = 2'd0,
    CMD_DATA_ROW  = 2'd1,
    CMD_READ_SUM  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic          accept;
    logic          clr_we;
    logic          scan_rd;
    logic [AW-1:0] addr;
    logic          read_cap;
    logic          out_load;
  } msa_ctrl_t;

  typedef struct packed {
    logic             out_free;
    logic             scan_pend;
    logic [CNT_W-1:0] n_act;
  } msa_stat_t;

endpackage

@@ src/msa_ram.sv @@
// ----------------------------------------------------------------------------
// msa_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module msa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/msa_ctrl.sv @@
// ----------------------------------------------------------------------------
// msa_ctrl: sequencer for the moment superset accumulator
// Runs the clearing pass after reset, takes one command at a time, walks
// the table for a data row and hands each result to the output register.
// ----------------------------------------------------------------------------
module msa_ctrl
  import msa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_stall,
  input  msa_stat_t        stat,
  output msa_ctrl_t        ctrl
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ctrl          = '0;
    ctrl.addr     = cnt_r[AW-1:0];
    case (state_r)
      ST_CLEAR: begin
        ctrl.clr_we = 1'b1;
        if (cnt_r == CNT_W'(NUM_MOMENTS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.accept = 1'b1;
          cnt_nxt     = '0;
          case (cmd_t'(in_command))
            CMD_DATA_ROW: state_nxt = ST_SWEEP;
            CMD_READ_SUM: state_nxt = ST_READ;
            default:      state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_SWEEP: begin
        if (cnt_r < stat.n_act) begin
          ctrl.scan_rd = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
        end else if (!stat.scan_pend) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_READ: begin
        ctrl.read_cap = 1'b1;
        state_nxt     = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

@@ src/msa_datapath.sv @@
// ----------------------------------------------------------------------------
// msa_datapath: key and sum tables, containment test and result registers
// Holds the active entry count, the two table memories, the one-stage
// read-compare-writeback pipeline of the sweep and the output register.
// ----------------------------------------------------------------------------
module msa_datapath
  import msa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [IDX_W-1:0]  in_moment_index,
  input  logic [KEY_W-1:0]  in_key_bits,
  input  logic [VAL_W-1:0]  in_row_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VAL_W-1:0]  out_sum_value,
  output logic [MCNT_W-1:0] out_match_count,
  output logic              out_index_error,
  input  msa_ctrl_t         ctrl,
  output msa_stat_t         stat
);

  logic [CNT_W-1:0]  n_act_r, n_act_nxt;
  logic [KEY_W-1:0]  row_key_r, row_key_nxt;
  logic [VAL_W-1:0]  row_val_r, row_val_nxt;
  logic              err_r, err_nxt;
  logic [VAL_W-1:0]  rsum_r, rsum_nxt;
  logic [MCNT_W-1:0] mcnt_r, mcnt_nxt;
  logic              p_vld_r;
  logic [AW-1:0]     p_addr_r;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_sum_r;
  logic [MCNT_W-1:0] out_mcnt_r;
  logic              out_err_r;

  logic              idx_ok;
  logic              is_key_wr;
  logic              hit;
  logic [AW-1:0]     in_addr;
  logic [KEY_W-1:0]  key_rdata;
  logic [VAL_W-1:0]  sum_rdata;
  logic              key_we;
  logic              sum_we;
  logic [AW-1:0]     sum_waddr;
  logic [VAL_W-1:0]  sum_wdata;
  logic [AW-1:0]     sum_raddr;

  assign in_addr   = AW'(in_moment_index);
  assign idx_ok    = (CMP_W'(in_moment_index) < CMP_W'(n_act_r));
  assign is_key_wr = (in_command == CMD_KEY_WRITE);
  assign hit       = ((key_rdata & row_key_r) == key_rdata);

  assign key_we    = ctrl.accept && is_key_wr && idx_ok;

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = ctrl.addr;
    sum_wdata = '0;
    if (ctrl.clr_we) begin
      sum_we = 1'b1;
    end else if (key_we) begin
      sum_we    = 1'b1;
      sum_waddr = in_addr;
    end else if (p_vld_r && hit) begin
      sum_we    = 1'b1;
      sum_waddr = p_addr_r;
      sum_wdata = sum_rdata + row_val_r;
    end
  end

  assign sum_raddr = ctrl.scan_rd ? ctrl.addr : in_addr;

  msa_ram #(
    .WIDTH (KEY_W),
    .DEPTH (NUM_MOMENTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_addr),
    .wdata (in_key_bits & KEY_MASK),
    .raddr (ctrl.addr),
    .rdata (key_rdata)
  );

  msa_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NUM_MOMENTS)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  always_comb begin
    n_act_nxt   = n_act_r;
    row_key_nxt = row_key_r;
    row_val_nxt = row_val_r;
    err_nxt     = err_r;
    rsum_nxt    = rsum_r;
    mcnt_nxt    = mcnt_r;
    if (cfg_we) begin
      if (LIM_W'(cfg_wdata) > LIM_W'(NUM_MOMENTS)) begin
        n_act_nxt = CNT_W'(NUM_MOMENTS);
      end else begin
        n_act_nxt = CNT_W'(cfg_wdata);
      end
    end
    if (ctrl.accept) begin
      row_key_nxt = in_key_bits & KEY_MASK;
      row_val_nxt = in_row_value;
      err_nxt     = (is_key_wr || (in_command == CMD_READ_SUM)) && !idx_ok;
      rsum_nxt    = '0;
      mcnt_nxt    = '0;
    end
    if (ctrl.read_cap) begin
      rsum_nxt = err_r ? '0 : sum_rdata;
    end
    if (p_vld_r && hit && (mcnt_r != MCNT_MAX)) begin
      mcnt_nxt = mcnt_r + 1'b1;
    end
  end

  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.scan_pend = p_vld_r;
  assign stat.n_act     = n_act_r;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_act_r     <= CNT_W'(N_RESET);
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      n_act_r     <= n_act_nxt;
      p_vld_r     <= ctrl.scan_rd;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_key_r <= row_key_nxt;
    row_val_r <= row_val_nxt;
    err_r     <= err_nxt;
    rsum_r    <= rsum_nxt;
    mcnt_r    <= mcnt_nxt;
    p_addr_r  <= ctrl.addr;
    if (ctrl.out_load) begin
      out_sum_r  <= rsum_r;
      out_mcnt_r <= mcnt_r;
      out_err_r  <= err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sum_value   = out_sum_r;
  assign out_match_count = out_mcnt_r;
  assign out_index_error = out_err_r;

endmodule

@@ src/moment_superset_accumulator.sv @@
// ----------------------------------------------------------------------------
// moment_superset_accumulator: subset-containment sum aggregation
// Each command on the input channel produces exactly one result transfer.
// Command 0 stores a moment key and clears its sum, command 1 adds a row
// value to every active moment whose key is contained in the row key, and
// command 2 returns the sum of one moment. Command 3 returns all zeros.
// Both channels use valid and stall; cfg_we writes the active moment count
// and is taken at any time, but is meant to change only while idle.
// A key write or an unused command goes from idle straight to the finish
// state, a read passes through the read state and a data row sweeps the n
// active entries, n being the active moment count. One command is in flight
// at a time, so a new command is taken only once the result is loaded and
// the sequencer is idle again. A data row walks the table one entry per
// cycle through the sum memory's single read port and writes each entry
// back in the cycle after its read. After reset the sum table is cleared,
// one entry per cycle over all NUM_MOMENTS (1024) entries; in_stall stays
// high during that pass. When the receiver stalls, the result is held in
// the output register and the next command is accepted, but its result
// waits until the register is free.
// ----------------------------------------------------------------------------
module moment_superset_accumulator
  import msa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [IDX_W-1:0]  in_moment_index,
  input  logic [KEY_W-1:0]  in_key_bits,
  input  logic [VAL_W-1:0]  in_row_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VAL_W-1:0]  out_sum_value,
  output logic [MCNT_W-1:0] out_match_count,
  output logic              out_index_error
);

  msa_ctrl_t ctrl;
  msa_stat_t stat;

  msa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  msa_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_command),
    .in_moment_index (in_moment_index),
    .in_key_bits     (in_key_bits),
    .in_row_value    (in_row_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sum_value   (out_sum_value),
    .out_match_count (out_match_count),
    .out_index_error (out_index_error),
    .ctrl            (ctrl),
    .stat            (stat)
  );

endmodule

@@ tb/sv/moment_superset_accumulator_checker.sv @@
// ----------------------------------------------------------------------------
// moment_superset_accumulator_checker: result checker for the accumulator
// Watches the configuration port and both channels. Every input transfer
// is applied to a private copy of the moment table, and the response it
// should produce is queued. Every result transfer is compared field by
// field with the oldest queued response.
// ----------------------------------------------------------------------------
module moment_superset_accumulator_checker
  import msa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [IDX_W-1:0]  in_moment_index,
  input  logic [KEY_W-1:0]  in_key_bits,
  input  logic [VAL_W-1:0]  in_row_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [VAL_W-1:0]  out_sum_value,
  input  logic [MCNT_W-1:0] out_match_count,
  input  logic              out_index_error,
  output int                mismatch_count,
  output int                responses_pending
);

  typedef struct packed {
    logic [VAL_W-1:0]  sum_value;
    logic [MCNT_W-1:0] match_count;
    logic              index_error;
  } moment_response_t;

  logic [KEY_W-1:0] key_store [NUM_MOMENTS];
  logic [VAL_W-1:0] sum_store [NUM_MOMENTS];
  logic [CFG_W-1:0] moment_limit;
  moment_response_t moment_responses [$];

  function automatic moment_response_t run_moment_command(
    input logic [CMD_W-1:0] command,
    input logic [IDX_W-1:0] index,
    input logic [KEY_W-1:0] key_bits,
    input logic [VAL_W-1:0] row_value
  );
    moment_response_t resp;
    int               active;
    int               i;
    logic [KEY_W-1:0] masked_key;
    resp       = '0;
    active     = (moment_limit > NUM_MOMENTS) ? NUM_MOMENTS : int'(moment_limit);
    masked_key = key_bits & KEY_MASK;
    case (command)
      CMD_KEY_WRITE: begin
        if (index < active) begin
          key_store[index] = masked_key;
          sum_store[index] = '0;
        end else begin
          resp.index_error = 1'b1;
        end
      end
      CMD_DATA_ROW: begin
        for (i = 0; i < active; i++) begin
          if ((key_store[i] & masked_key) == key_store[i]) begin
            sum_store[i] = sum_store[i] + row_value;
            if (resp.match_count != MCNT_MAX) begin
              resp.match_count = resp.match_count + 1'b1;
            end
          end
        end
      end
      CMD_READ_SUM: begin
        if (index < active) begin
          resp.sum_value = sum_store[index];
        end else begin
          resp.index_error = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return resp;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin : monitor
    moment_response_t seen;
    moment_response_t want;
    int               i;
    if (!rst_n) begin
      for (i = 0; i < NUM_MOMENTS; i++) begin
        key_store[i] = '0;
        sum_store[i] = '0;
      end
      moment_limit = CFG_W'(NUM_RESET);
      moment_responses.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        moment_limit = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        seen = {out_sum_value, out_match_count, out_index_error};
        if (moment_responses.size() == 0) begin
          note_failure($sformatf("result transfer with none outstanding: sum %h count %0d err %0b",
                                 seen.sum_value, seen.match_count, seen.index_error));
        end else begin
          want = moment_responses.pop_front();
          if (seen !== want) begin
            note_failure($sformatf({"result mismatch: sum exp %h got %h, count exp %0d got %0d,",
                                    " err exp %0b got %0b"},
                                   want.sum_value, seen.sum_value,
                                   want.match_count, seen.match_count,
                                   want.index_error, seen.index_error));
          end
        end
      end
      if (in_valid && !in_stall) begin
        moment_responses.push_back(run_moment_command(in_command, in_moment_index,
                                                      in_key_bits, in_row_value));
      end
    end
    responses_pending = moment_responses.size();
  end

endmodule

@@ tb/sv/moment_superset_accumulator_test.sv @@
// ----------------------------------------------------------------------------
// moment_superset_accumulator_test: top level of the accumulator testbench
// Runs directed commands at the size extremes, fills the low part of the
// moment table and then random command streams over several table sizes
// and idling mixes. Data rows only run over entries whose keys are written.
// Results are checked by the checker instance; this module drives stimulus,
// guards against hangs and reports the verdict.
// ----------------------------------------------------------------------------
module moment_superset_accumulator_test;
  import msa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT     = 20000;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 61;
  localparam int FILL_COUNT      = 256;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command;
  logic [IDX_W-1:0]  in_moment_index;
  logic [KEY_W-1:0]  in_key_bits;
  logic [VAL_W-1:0]  in_row_value;
  logic              out_valid;
  logic              out_stall;
  logic [VAL_W-1:0]  out_sum_value;
  logic [MCNT_W-1:0] out_match_count;
  logic              out_index_error;

  int sender_idle_pct;
  int receiver_idle_pct;
  int active_count;
  int quiet_cycles;
  int mismatch_count;
  int responses_pending;

  moment_superset_accumulator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_moment_index (in_moment_index),
    .in_key_bits     (in_key_bits),
    .in_row_value    (in_row_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sum_value   (out_sum_value),
    .out_match_count (out_match_count),
    .out_index_error (out_index_error)
  );

  moment_superset_accumulator_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_moment_index   (in_moment_index),
    .in_key_bits       (in_key_bits),
    .in_row_value      (in_row_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sum_value     (out_sum_value),
    .out_match_count   (out_match_count),
    .out_index_error   (out_index_error),
    .mismatch_count    (mismatch_count),
    .responses_pending (responses_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] random_moment_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return random_word();
      2:       return '1;
      default: return random_word() & random_word() & random_word();
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] random_row_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return random_word();
      default: return random_word() | random_word() | random_word();
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] random_row_value();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return VAL_W'($urandom_range(0, 15));
      default: return random_word();
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] random_index();
    if (active_count > 0 && $urandom_range(0, 3) != 0) begin
      return IDX_W'($urandom_range(0, active_count - 1));
    end
    return IDX_W'($urandom_range(0, NUM_MOMENTS - 1));
  endfunction

  // Returns at the falling edge after the transfer with valid still high;
  // the caller either drives the next command at once or drops valid.
  task automatic send_command(
    input logic [CMD_W-1:0] command,
    input logic [IDX_W-1:0] index,
    input logic [KEY_W-1:0] key_bits,
    input logic [VAL_W-1:0] row_value
  );
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_command      = command;
    in_moment_index = index;
    in_key_bits     = key_bits;
    in_row_value    = row_value;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic send_random_command();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_command(CMD_KEY_WRITE, random_index(), random_moment_key(), random_word());
    end else if (pick < 65 && active_count <= FILL_COUNT) begin
      send_command(CMD_DATA_ROW, random_index(), random_row_key(), random_row_value());
    end else if (pick < 95) begin
      send_command(CMD_READ_SUM, random_index(), random_word(), random_word());
    end else begin
      send_command(CMD_UNUSED, random_index(), random_word(), random_word());
    end
  endtask

  task automatic write_moment_count(input logic [CFG_W-1:0] value);
    in_valid = 1'b0;
    while (responses_pending != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we       = 1'b0;
    active_count = (value > NUM_MOMENTS) ? NUM_MOMENTS : int'(value);
  endtask

  initial begin : stimulus
    int k;
    int phase;
    int limit;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_command        = CMD_KEY_WRITE;
    in_moment_index   = '0;
    in_key_bits       = '0;
    in_row_value      = '0;
    out_stall         = 1'b0;
    quiet_cycles      = 0;
    sender_idle_pct   = 28;
    receiver_idle_pct = 74;
    active_count      = NUM_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    while (in_stall) begin
      @(negedge clk);
    end

    write_moment_count(CFG_W'(4));
    send_command(CMD_KEY_WRITE, 10'd0, '0, '1);
    send_command(CMD_KEY_WRITE, 10'd1, '1, '0);
    send_command(CMD_KEY_WRITE, 10'd2, 64'h1, '1);
    send_command(CMD_KEY_WRITE, 10'd3, 64'h8000_0000_0000_0001, '0);
    send_command(CMD_KEY_WRITE, 10'd4, '1, '1);
    send_command(CMD_KEY_WRITE, 10'd1023, '1, '1);
    send_command(CMD_DATA_ROW, 10'd0, '1, '1);
    send_command(CMD_DATA_ROW, 10'd1023, '0, 64'd5);
    send_command(CMD_DATA_ROW, 10'd2, 64'h1, 64'h8000_0000_0000_0000);
    send_command(CMD_DATA_ROW, 10'd3, 64'h8000_0000_0000_0001, '1);
    for (k = 0; k < 4; k++) begin
      send_command(CMD_READ_SUM, IDX_W'(k), '0, '0);
    end
    send_command(CMD_READ_SUM, 10'd4, '1, '1);
    send_command(CMD_READ_SUM, 10'd1023, '0, '0);
    send_command(CMD_UNUSED, '1, '1, '1);
    send_command(CMD_KEY_WRITE, 10'd1, 64'h0000_ffff_0000_0000, '0);
    send_command(CMD_READ_SUM, 10'd1, '0, '0);

    write_moment_count('0);
    send_command(CMD_KEY_WRITE, 10'd0, 64'h1, '0);
    send_command(CMD_DATA_ROW, 10'd0, '1, '1);
    send_command(CMD_READ_SUM, 10'd0, '0, '0);

    write_moment_count(CFG_W'(1));
    send_command(CMD_DATA_ROW, 10'd5, '1, 64'd7);
    send_command(CMD_READ_SUM, 10'd0, '0, '0);
    send_command(CMD_READ_SUM, 10'd1, '0, '0);

    write_moment_count(CFG_W'(FILL_COUNT));
    for (k = 0; k < FILL_COUNT; k++) begin
      send_command(CMD_KEY_WRITE, IDX_W'(k), random_moment_key(), random_word());
    end
    for (k = 0; k < 6; k++) begin
      send_command(CMD_DATA_ROW, random_index(), random_row_key(), random_row_value());
    end
    for (k = 0; k < 6; k++) begin
      send_command(CMD_READ_SUM, random_index(), random_word(), random_word());
    end
    send_command(CMD_READ_SUM, IDX_W'(FILL_COUNT - 1), '0, '0);
    send_command(CMD_KEY_WRITE, IDX_W'(FILL_COUNT), '1, '0);

    write_moment_count(CFG_W'(NUM_MOMENTS));
    send_command(CMD_READ_SUM, 10'd1023, '0, '0);
    send_command(CMD_READ_SUM, 10'd0, '0, '0);

    write_moment_count('1);
    send_command(CMD_KEY_WRITE, 10'd1023, '1, '0);
    send_command(CMD_READ_SUM, 10'd1023, '0, '0);
    send_command(CMD_READ_SUM, 10'd0, '0, '0);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 3) begin
        sender_idle_pct   = 74;
        receiver_idle_pct = 28;
      end else if (phase == 6) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      if (phase == 0) begin
        limit = 1;
      end else if (phase == 4) begin
        limit = FILL_COUNT;
      end else if (phase == 7) begin
        limit = 2047;
      end else begin
        limit = $urandom_range(2, 48);
      end
      write_moment_count(CFG_W'(limit));
      repeat (ITEMS_PER_PHASE) send_random_command();
    end

    in_valid = 1'b0;
    while (responses_pending != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && responses_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
